FILE: rtl/ret_pkg.sv
`timescale 1ns / 1ps
// review episode tracker package: codes, event kinds, result struct, register defaults
// no dependencies

package ret_pkg;

    // candidate and output codes
    localparam logic [7:0] CODE_WARN1   = 8'd17;
    localparam logic [7:0] CODE_WARN2   = 8'd18;
    localparam logic [7:0] CODE_REVIEW  = 8'd29;
    localparam logic [7:0] CODE_INVALID = 8'd34;

    localparam int CODE_BITS     = 8;
    localparam int COUNT_BITS    = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int OUT_DATA_BITS = 24;
    localparam int OUT_USER_BITS = 4;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_FRAMES = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ACTIVE_US  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN_US    = 2'd2;

    // register reset values
    localparam logic [7:0]  CONFIRM_FRAMES_RST = 8'd3;
    localparam logic [31:0] MAX_ACTIVE_US_RST  = 32'd10000000;
    localparam logic [31:0] COOLDOWN_US_RST    = 32'd5000000;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_INVALID    = 4'd1,
        EV_ROLLBACK   = 4'd2,
        EV_PROMOTE    = 4'd3,
        EV_DISAPPEAR  = 4'd4,
        EV_REPEAT     = 4'd5,
        EV_SUPPRESSED = 4'd6,
        EV_ACTIVE     = 4'd7,
        EV_TIMEOUT    = 4'd8,
        EV_PENDING    = 4'd9,
        EV_ENTER      = 4'd10
    } ev_kind_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]  out_code;
        logic                  is_active;
        logic [COUNT_BITS-1:0] confirm_count;
        logic                  emit_flag;
        ev_kind_t              event_kind;
    } res_t;

endpackage

FILE: rtl/ret_core.sv
`timescale 1ns / 1ps
// episode state registers, configuration registers and the per-item decision logic
// depends on ret_pkg

module ret_core import ret_pkg::*; #(
    parameter int TIME_BITS     = 48,
    parameter int KEY_PART_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                       step,
    input  logic [TIME_BITS-1:0]       stamp,
    input  logic                       stamp_bad,
    input  logic [CODE_BITS-1:0]       cand,
    input  logic [5*KEY_PART_BITS-1:0] key,
    output res_t                       res
);

    localparam int KEY_BITS = 5 * KEY_PART_BITS;

    // configuration
    logic [7:0]  confirm_frames_reg;
    logic [31:0] max_active_us_reg;
    logic [31:0] cooldown_us_reg;
    logic        cfg_clear;

    // episode state
    logic                  have_stamp_reg,    have_stamp_next;
    logic [TIME_BITS-1:0]  last_stamp_reg,    last_stamp_next;
    logic [CODE_BITS-1:0]  last_code_reg,     last_code_next;
    logic                  pending_flag_reg,  pending_flag_next;
    logic [COUNT_BITS-1:0] pending_count_reg, pending_count_next;
    logic [TIME_BITS-1:0]  pending_since_reg, pending_since_next;
    logic [KEY_BITS-1:0]   pending_key_reg,   pending_key_next;
    logic                  active_flag_reg,   active_flag_next;
    logic [TIME_BITS-1:0]  active_since_reg,  active_since_next;
    logic [KEY_BITS-1:0]   active_key_reg,    active_key_next;
    logic                  cooldown_flag_reg, cooldown_flag_next;
    logic [TIME_BITS-1:0]  cooldown_until_reg, cooldown_until_next;
    logic [KEY_BITS-1:0]   cooldown_key_reg,  cooldown_key_next;

    // time compares
    logic [TIME_BITS-1:0]  d_fwd, d_back, act_elapsed, cd_until;
    logic [TIME_BITS:0]    cd_sum;
    logic                  t_ge, rollback, near, in_limit, cd_over, warn;
    logic                  pend_hit;
    logic [COUNT_BITS-1:0] new_cnt;

    assign cfg_clear = cfg_we && (cfg_index == REG_CONFIRM_FRAMES ||
                                  cfg_index == REG_MAX_ACTIVE_US ||
                                  cfg_index == REG_COOLDOWN_US);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            confirm_frames_reg <= CONFIRM_FRAMES_RST;
            max_active_us_reg  <= MAX_ACTIVE_US_RST;
            cooldown_us_reg    <= COOLDOWN_US_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CONFIRM_FRAMES: confirm_frames_reg <= cfg_wdata[7:0];
                REG_MAX_ACTIVE_US:  max_active_us_reg  <= cfg_wdata;
                REG_COOLDOWN_US:    cooldown_us_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign warn        = (cand == CODE_WARN1) || (cand == CODE_WARN2);
    assign d_fwd       = stamp - last_stamp_reg;
    assign d_back      = last_stamp_reg - stamp;
    assign t_ge        = stamp >= last_stamp_reg;
    assign rollback    = have_stamp_reg && !t_ge && (d_back > TIME_BITS'(1));
    assign near        = have_stamp_reg && ((t_ge ? d_fwd : d_back) <= TIME_BITS'(1));
    assign act_elapsed = stamp - active_since_reg;
    assign in_limit    = (stamp < active_since_reg) ||
                         (act_elapsed <= TIME_BITS'(max_active_us_reg));
    assign cd_sum      = {1'b0, stamp} + (TIME_BITS + 1)'(cooldown_us_reg);
    // cooldown end saturates at the top of the time range
    assign cd_until    = cd_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : cd_sum[TIME_BITS-1:0];
    assign cd_over     = stamp >= cooldown_until_reg;
    assign pend_hit    = pending_flag_reg && !active_flag_reg && (key == pending_key_reg);
    assign new_cnt     = !pend_hit ? COUNT_BITS'(1) :
                         (&pending_count_reg) ? pending_count_reg :
                         pending_count_reg + COUNT_BITS'(1);

    always_comb begin
        have_stamp_next     = have_stamp_reg;
        last_stamp_next     = last_stamp_reg;
        last_code_next      = last_code_reg;
        pending_flag_next   = pending_flag_reg;
        pending_count_next  = pending_count_reg;
        pending_since_next  = pending_since_reg;
        pending_key_next    = pending_key_reg;
        active_flag_next    = active_flag_reg;
        active_since_next   = active_since_reg;
        active_key_next     = active_key_reg;
        cooldown_flag_next  = cooldown_flag_reg;
        cooldown_until_next = cooldown_until_reg;
        cooldown_key_next   = cooldown_key_reg;

        res.out_code      = cand;
        res.is_active     = 1'b0;
        res.confirm_count = '0;
        res.emit_flag     = 1'b0;
        res.event_kind    = EV_NONE;

        priority if (stamp_bad) begin
            have_stamp_next    = 1'b0;
            last_stamp_next    = '0;
            last_code_next     = CODE_INVALID;
            pending_flag_next  = 1'b0;
            pending_count_next = '0;
            pending_since_next = '0;
            active_flag_next   = 1'b0;
            active_since_next  = '0;
            cooldown_flag_next = 1'b0;
            cooldown_until_next = '0;
            res.out_code   = CODE_INVALID;
            res.emit_flag  = 1'b1;
            res.event_kind = EV_INVALID;
        end else if (rollback) begin
            // clear, but keep the new stamp as the last one
            have_stamp_next    = 1'b1;
            last_stamp_next    = stamp;
            last_code_next     = CODE_INVALID;
            pending_flag_next  = 1'b0;
            pending_count_next = '0;
            pending_since_next = '0;
            active_flag_next   = 1'b0;
            active_since_next  = '0;
            cooldown_flag_next = 1'b0;
            cooldown_until_next = '0;
            res.out_code   = CODE_INVALID;
            res.emit_flag  = 1'b1;
            res.event_kind = EV_ROLLBACK;
        end else if (cand != CODE_REVIEW) begin
            // warning or pass code, same for a repeated stamp except no time update
            if (!near) begin
                have_stamp_next = 1'b1;
                last_stamp_next = stamp;
            end
            pending_flag_next  = 1'b0;
            pending_count_next = '0;
            active_flag_next   = 1'b0;
            if (warn) begin
                cooldown_flag_next = 1'b0;
            end else if (!near && cooldown_flag_reg && cd_over) begin
                cooldown_flag_next = 1'b0;
            end
            last_code_next = cand;
            res.emit_flag  = active_flag_reg || pending_flag_reg;
            res.event_kind = !(active_flag_reg || pending_flag_reg) ? EV_NONE :
                             warn ? EV_PROMOTE : EV_DISAPPEAR;
        end else if (near) begin
            // repeated review frame reports state and changes nothing
            res.out_code      = last_code_reg;
            res.is_active     = active_flag_reg;
            res.confirm_count = pending_count_reg;
            res.event_kind    = EV_REPEAT;
        end else begin
            have_stamp_next = 1'b1;
            last_stamp_next = stamp;
            if (cooldown_flag_reg && (key == cooldown_key_reg) && !cd_over) begin
                last_code_next = CODE_INVALID;
                res.out_code   = CODE_INVALID;
                res.event_kind = EV_SUPPRESSED;
            end else begin
                if (cooldown_flag_reg && cd_over) begin
                    cooldown_flag_next = 1'b0;
                end
                if (active_flag_reg && (key == active_key_reg) && in_limit) begin
                    last_code_next    = CODE_REVIEW;
                    res.out_code      = CODE_REVIEW;
                    res.is_active     = 1'b1;
                    res.confirm_count = pending_count_reg;
                    res.event_kind    = EV_ACTIVE;
                end else if (active_flag_reg && (key == active_key_reg)) begin
                    // episode outlasted its limit: start re-entry cooldown
                    active_flag_next    = 1'b0;
                    pending_flag_next   = 1'b0;
                    pending_count_next  = '0;
                    cooldown_flag_next  = 1'b1;
                    cooldown_key_next   = key;
                    cooldown_until_next = cd_until;
                    last_code_next      = CODE_INVALID;
                    res.out_code        = CODE_INVALID;
                    res.emit_flag       = 1'b1;
                    res.event_kind      = EV_TIMEOUT;
                end else begin
                    // other key drops any active episode, then confirm
                    active_flag_next   = 1'b0;
                    pending_count_next = new_cnt;
                    if (!pend_hit) begin
                        pending_key_next   = key;
                        pending_since_next = stamp;
                    end
                    res.confirm_count = new_cnt;
                    if (new_cnt < confirm_frames_reg) begin
                        pending_flag_next = 1'b1;
                        last_code_next    = CODE_INVALID;
                        res.out_code      = CODE_INVALID;
                        res.event_kind    = EV_PENDING;
                    end else begin
                        pending_flag_next = 1'b0;
                        active_flag_next  = 1'b1;
                        active_key_next   = key;
                        active_since_next = pend_hit ? pending_since_reg : stamp;
                        last_code_next    = CODE_REVIEW;
                        res.out_code      = CODE_REVIEW;
                        res.is_active     = 1'b1;
                        res.emit_flag     = 1'b1;
                        res.event_kind    = EV_ENTER;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_clear) begin
            have_stamp_reg     <= 1'b0;
            last_stamp_reg     <= '0;
            last_code_reg      <= CODE_INVALID;
            pending_flag_reg   <= 1'b0;
            pending_count_reg  <= '0;
            pending_since_reg  <= '0;
            active_flag_reg    <= 1'b0;
            active_since_reg   <= '0;
            cooldown_flag_reg  <= 1'b0;
            cooldown_until_reg <= '0;
        end else if (step) begin
            have_stamp_reg     <= have_stamp_next;
            last_stamp_reg     <= last_stamp_next;
            last_code_reg      <= last_code_next;
            pending_flag_reg   <= pending_flag_next;
            pending_count_reg  <= pending_count_next;
            pending_since_reg  <= pending_since_next;
            active_flag_reg    <= active_flag_next;
            active_since_reg   <= active_since_next;
            cooldown_flag_reg  <= cooldown_flag_next;
            cooldown_until_reg <= cooldown_until_next;
        end
    end

    // keys are only read while their flag is set
    always_ff @(posedge aclk) begin
        if (step) begin
            pending_key_reg  <= pending_key_next;
            active_key_reg   <= active_key_next;
            cooldown_key_reg <= cooldown_key_next;
        end
    end

`ifndef SYNTH
    a_pend_act_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(active_flag_reg && pending_flag_reg))
        else $error("pending and active both set");

    a_bad_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && stamp_bad |=> !have_stamp_reg && !active_flag_reg && !cooldown_flag_reg)
        else $error("bad stamp did not clear state");

    a_rollback_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg_we && res.event_kind == EV_ROLLBACK
        |=> have_stamp_reg && last_stamp_reg == $past(stamp))
        else $error("rollback did not keep stamp");

    a_enter_active: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg_we && res.event_kind == EV_ENTER |=> active_flag_reg && !pending_flag_reg)
        else $error("enter did not set active");
`endif

endmodule

FILE: rtl/review_episode_tracker.sv
`timescale 1ns / 1ps
// review episode tracker top level: stream ports, input and result registers
// depends on ret_pkg and ret_core

// Takes one frame item per clock cycle while the output side keeps up, and returns exactly
// one result item per frame. An accepted item waits in the input register until the result
// register is free or being drained; it then passes the combinational decision path in
// ret_core, which sits between the input register and the result register and updates the
// episode state as each item passes, and its result is offered from the result register.
// One item can be accepted while a finished result waits in the result register; it then
// waits in the input register and holds the input off until the result drains. A write to
// one of the three configuration registers takes effect on the next cycle and also clears
// the episode state; write only while idle. There is no clearing pass after reset.

module review_episode_tracker import ret_pkg::*; #(
    parameter int TIME_BITS     = 48,
    parameter int KEY_PART_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // frame items in
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // stamp_us, cand code, lifecycle_id, cargo_track, obstacle_track,
    // pose_gen, map_gen
    input  logic [((TIME_BITS + CODE_BITS + 5 * KEY_PART_BITS + 7) / 8) * 8 - 1:0]
                                     s_axis_tdata,
    // stamp_bad
    input  logic                     s_axis_tuser,
    // result items out
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_code, is_active, confirm_count, emit_flag, zero fill
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // event_kind
    output logic [OUT_USER_BITS-1:0] m_axis_tuser
);

    localparam int KEY_BITS     = 5 * KEY_PART_BITS;
    localparam int IN_RAW_BITS  = TIME_BITS + CODE_BITS + KEY_BITS;
    localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int CODE_LSB     = TIME_BITS;
    localparam int KEY_LSB      = TIME_BITS + CODE_BITS;

    // input register
    logic                    in_valid_reg;
    logic [IN_DATA_BITS-1:0] in_data_reg;
    logic                    in_bad_reg;

    // result register
    logic                     out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic [OUT_USER_BITS-1:0] out_user_reg;

    logic advance;
    res_t res;

    // the held item moves on when the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= s_axis_tdata;
            in_bad_reg  <= s_axis_tuser;
        end
    end

    // decision logic and episode state
    ret_core #(
        .TIME_BITS     (TIME_BITS),
        .KEY_PART_BITS (KEY_PART_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .stamp     (in_data_reg[TIME_BITS-1:0]),
        .stamp_bad (in_bad_reg),
        .cand      (in_data_reg[CODE_LSB +: CODE_BITS]),
        .key       (in_data_reg[KEY_LSB +: KEY_BITS]),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {6'b0, res.emit_flag, res.confirm_count,
                             res.is_active, res.out_code};
            out_user_reg <= res.event_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
